>>> rtl/spo_pkg.sv
package spo_pkg;

    localparam int SPO_MAX_SAMPLES = 65536;

    localparam int FRAC_W   = 16;
    localparam int SAMPLE_W = 16;
    localparam int AMP_W    = 17;
    localparam int FREQ_W   = 16;
    localparam int RATE_W   = 18;
    localparam int LEN_W    = 17;
    localparam int PHASE_W  = 36;
    localparam int HI_W     = PHASE_W - FRAC_W;
    localparam int ADV_W    = 34;
    localparam int PROD_NUM_W = 2 * FREQ_W;
    localparam int NUM_W    = PROD_NUM_W + FRAC_W;
    localparam int DEN_W    = 34;
    localparam int STEP_W   = 6;
    localparam int MUL_W    = 19;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int SCALED_W = PROD_W - FRAC_W;
    localparam int CFG_W    = 18;
    localparam int CFG_IDX_W = 2;
    localparam int ACT_W    = 2;

    localparam logic [15:0] REF_DIVISOR = 16'd44000;
    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(44100);

    localparam logic [ACT_W-1:0] ACT_LOAD = 2'd0;
    localparam logic [ACT_W-1:0] ACT_CTRL = 2'd1;
    localparam logic [ACT_W-1:0] ACT_TICK = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIG_FREQ   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_LEN  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CMUL_NUM,
        S_CMUL_DEN,
        S_CDIV,
        S_CDIV_WAIT,
        S_MOD1,
        S_MOD1_WAIT,
        S_READ,
        S_MUL,
        S_SCALE,
        S_MOD2,
        S_MOD2_WAIT,
        S_PUT
    } t_state;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } t_div_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

>>> rtl/sample_playback_oscillator_unit.sv
// sample playback oscillator: plays a loop of signed 16-bit samples under a
// 20.16 phase accumulator.
// requests come in on i_in_valid / o_in_ready; i_action picks the kind:
//   load     - writes one sample word, no result
//   control  - restarts the phase on a rising trigger and works out the
//              phase advance; no result
//   tick     - one result on o_out_valid / i_out_ready; gate high with a
//              nonzero length first reads, scales and advances the phase
// the shared shift-subtract divider runs 48 steps for the advance and
// 20 steps for each of the two phase wraps of a tick.
// one request is worked on at a time; o_in_ready is high only when idle.
// a finished result sits in the output register and a new request is taken
// meanwhile; if a second result is ready before the first is taken the
// block holds it and waits.
// config registers: the user writes them through i_cfg_we / i_cfg_index /
// i_cfg_data only while idle; the block does not enforce it. reset clears
// phase, advance, trigger history and last output; not the sample memory.
module sample_playback_oscillator_unit
    import spo_pkg::*;
#(
    parameter int MAX_SAMPLES = SPO_MAX_SAMPLES
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [ACT_W-1:0]           i_action,
    input  logic [15:0]                i_load_index,
    input  logic signed [SAMPLE_W-1:0] i_load_value,
    input  logic [FREQ_W-1:0]          i_freq,
    input  logic                       i_trig,
    input  logic                       i_gate,
    input  logic [AMP_W-1:0]           i_amp,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [SAMPLE_W-1:0] o_sample_out,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_W-1:0]           i_cfg_data
);

    localparam int ADDR_W = $clog2(MAX_SAMPLES);

    t_state r_state, n_state;

    logic [FREQ_W-1:0]     r_orig_freq;
    logic [RATE_W-1:0]     r_sample_rate;
    logic [LEN_W-1:0]      r_sample_length;

    logic [PHASE_W-1:0]    r_pos, n_pos;
    logic [ADV_W-1:0]      r_adv, n_adv;
    logic                  r_prev_trig, n_prev_trig;
    logic [SAMPLE_W-1:0]   r_last, n_last;
    logic [AMP_W-1:0]      r_amp, n_amp;
    logic [FREQ_W-1:0]     r_freq, n_freq;
    logic signed [PROD_W-1:0] r_prod, n_prod;
    logic [PROD_NUM_W-1:0] r_num, n_num;
    logic                  r_out_valid, n_out_valid;
    logic [SAMPLE_W-1:0]   r_out_data, n_out_data;

    logic [LEN_W-1:0]      len;
    logic                  in_acc;
    logic                  load_in_range;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [SCALED_W-1:0] scaled;
    logic [SAMPLE_W-1:0]      sat_val;

    t_div_cmd         div_cmd;
    t_div_stat        div_stat;
    logic [NUM_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    logic [NUM_W-1:0] div_quot;
    logic [DEN_W-1:0] div_rem;

    logic              ram_we;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [SAMPLE_W-1:0] ram_rdata;

    spo_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (div_cmd),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_stat  (div_stat),
        .o_quot  (div_quot),
        .o_rem   (div_rem)
    );

    spo_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_SAMPLES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ADDR_W'(i_load_index)),
        .i_wdata (i_load_value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // loop length capped at the memory depth
    always_comb begin
        if (32'(r_sample_length) > MAX_SAMPLES) begin
            len = LEN_W'(MAX_SAMPLES);
        end else begin
            len = r_sample_length;
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign in_acc        = i_in_valid && o_in_ready;
    assign load_in_range = (32'(i_load_index) < MAX_SAMPLES);

    // shared multiplier, operands chosen by the sequencer
    assign mul_p = mul_a * mul_b;

    // floor shift then saturate to 16 signed bits
    always_comb begin
        scaled = SCALED_W'(r_prod >>> FRAC_W);
        if (scaled[SCALED_W-1:SAMPLE_W-1] == '0 ||
            scaled[SCALED_W-1:SAMPLE_W-1] == '1) begin
            sat_val = scaled[SAMPLE_W-1:0];
        end else if (scaled[SCALED_W-1]) begin
            sat_val = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            sat_val = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    end

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_adv       = r_adv;
        n_prev_trig = r_prev_trig;
        n_last      = r_last;
        n_amp       = r_amp;
        n_freq      = r_freq;
        n_prod      = r_prod;
        n_num       = r_num;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;

        div_cmd   = '0;
        div_num   = {r_pos[PHASE_W-1:FRAC_W], (NUM_W-HI_W)'(0)};
        div_den   = DEN_W'(len);
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = ADDR_W'(r_pos[PHASE_W-1:FRAC_W]);
        mul_a     = '0;
        mul_b     = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_action)
                        ACT_LOAD: begin
                            ram_we = load_in_range;
                        end
                        ACT_CTRL: begin
                            if (i_trig && !r_prev_trig) begin
                                n_pos = '0;
                            end
                            n_prev_trig = i_trig;
                            n_freq      = i_freq;
                            n_state     = S_CMUL_NUM;
                        end
                        ACT_TICK: begin
                            n_amp = i_amp;
                            if (!i_gate) begin
                                n_state = S_PUT;
                            end else if (len == '0) begin
                                n_last  = '0;
                                n_state = S_PUT;
                            end else begin
                                n_state = S_MOD1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CMUL_NUM: begin
                mul_a   = MUL_W'(r_freq);
                mul_b   = MUL_W'(r_orig_freq);
                n_prod  = mul_p;
                n_state = S_CMUL_DEN;
            end
            S_CMUL_DEN: begin
                n_num   = r_prod[PROD_NUM_W-1:0];
                mul_a   = MUL_W'(REF_DIVISOR);
                mul_b   = MUL_W'(r_sample_rate);
                n_prod  = mul_p;
                n_state = S_CDIV;
            end
            S_CDIV: begin
                div_num = {r_num, (NUM_W-PROD_NUM_W)'(0)};
                div_den = r_prod[DEN_W-1:0];
                if (r_prod[DEN_W-1:0] == '0) begin
                    n_adv   = '0;
                    n_state = S_IDLE;
                end else begin
                    div_cmd.start = 1'b1;
                    div_cmd.steps = STEP_W'(NUM_W);
                    n_state       = S_CDIV_WAIT;
                end
            end
            S_CDIV_WAIT: begin
                if (div_stat.done) begin
                    n_adv   = div_quot[ADV_W-1:0];
                    n_state = S_IDLE;
                end
            end
            S_MOD1: begin
                div_cmd.start = 1'b1;
                div_cmd.steps = STEP_W'(HI_W);
                n_state       = S_MOD1_WAIT;
            end
            S_MOD1_WAIT: begin
                if (div_stat.done) begin
                    n_pos   = {HI_W'(div_rem), r_pos[FRAC_W-1:0]};
                    n_state = S_READ;
                end
            end
            S_READ: begin
                ram_re  = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                mul_a   = MUL_W'(r_amp);
                mul_b   = MUL_W'($signed(ram_rdata));
                n_prod  = mul_p;
                n_state = S_SCALE;
            end
            S_SCALE: begin
                n_last  = sat_val;
                n_pos   = r_pos + PHASE_W'(r_adv);
                n_state = S_MOD2;
            end
            S_MOD2: begin
                div_cmd.start = 1'b1;
                div_cmd.steps = STEP_W'(HI_W);
                n_state       = S_MOD2_WAIT;
            end
            S_MOD2_WAIT: begin
                if (div_stat.done) begin
                    n_pos   = {HI_W'(div_rem), r_pos[FRAC_W-1:0]};
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                // wait here while an earlier result is still unclaimed
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_last;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_adv       <= '0;
            r_prev_trig <= 1'b0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_adv       <= n_adv;
            r_prev_trig <= n_prev_trig;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_amp      <= n_amp;
        r_freq     <= n_freq;
        r_prod     <= n_prod;
        r_num      <= n_num;
        r_out_data <= n_out_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_orig_freq     <= '0;
            r_sample_rate   <= RATE_RESET;
            r_sample_length <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ORIG_FREQ:   r_orig_freq     <= i_cfg_data[FREQ_W-1:0];
                CFG_SAMPLE_RATE: r_sample_rate   <= i_cfg_data[RATE_W-1:0];
                CFG_SAMPLE_LEN:  r_sample_length <= i_cfg_data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out_data;

    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == S_MOD1_WAIT || r_state == S_MOD2_WAIT ||
                           r_state == S_CDIV_WAIT))
        else $error("divider finished with no step waiting for it");

    a_div_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_cmd.start |-> !div_stat.busy)
        else $error("divider started while still busy");

    a_phase_wrapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUT && $past(r_state) == S_MOD2_WAIT) |->
            (r_pos[PHASE_W-1:FRAC_W] < HI_W'(len)))
        else $error("phase left outside the loop after a tick");

    a_result_from_put: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == S_PUT)
        else $error("result raised outside the output step");

endmodule

>>> rtl/spo_ram.sv
module spo_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/spo_div.sv
module spo_div
    import spo_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_cmd         i_cmd,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output t_div_stat        o_stat,
    output logic [NUM_W-1:0] o_quot,
    output logic [DEN_W-1:0] o_rem
);

    logic [NUM_W-1:0]  r_num, n_num;
    logic [DEN_W-1:0]  r_rem, n_rem;
    logic [DEN_W-1:0]  r_den, n_den;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic              r_done, n_done;

    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           ge;

    // one restoring step per cycle: bring down the next numerator bit
    always_comb begin
        trial = {r_rem, r_num[NUM_W-1]};
        ge    = (trial >= {1'b0, r_den});
        diff  = trial - {1'b0, r_den};

        n_num  = r_num;
        n_rem  = r_rem;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_done = 1'b0;

        if (i_cmd.start) begin
            n_num = i_num;
            n_den = i_den;
            n_rem = '0;
            n_cnt = i_cmd.steps;
        end else if (r_cnt != '0) begin
            n_num  = {r_num[NUM_W-2:0], ge};
            n_rem  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            n_cnt  = r_cnt - STEP_W'(1);
            n_done = (r_cnt == STEP_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num <= n_num;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_stat.busy = (r_cnt != '0);
    assign o_stat.done = r_done;
    assign o_quot      = r_num;
    assign o_rem       = r_rem;

endmodule

>>> dv/sample_playback_oscillator_unit_tb.sv
`timescale 1ns / 1ps

module sample_playback_oscillator_unit_tb;
    import spo_pkg::*;

    localparam logic [ACT_W-1:0]     ACT_NONE = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 64;
    localparam int RAND_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 80;

    typedef struct {
        logic [ACT_W-1:0]    action;
        logic [15:0]         index;
        logic [SAMPLE_W-1:0] value;
        logic [FREQ_W-1:0]   freq;
        logic                trig;
        logic                gate;
        logic [AMP_W-1:0]    amp;
    } t_req;

    typedef struct {
        t_req        req;
        logic        fixed;
        logic [15:0] fixed_val;
        int          ph;
    } t_row;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_ready;
    logic [ACT_W-1:0]           i_action;
    logic [15:0]                i_load_index;
    logic signed [SAMPLE_W-1:0] i_load_value;
    logic [FREQ_W-1:0]          i_freq;
    logic                       i_trig;
    logic                       i_gate;
    logic [AMP_W-1:0]           i_amp;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] o_sample_out;
    logic                       i_cfg_we;
    logic [CFG_IDX_W-1:0]       i_cfg_index;
    logic [CFG_W-1:0]           i_cfg_data;

    sample_playback_oscillator_unit uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_action     (i_action),
        .i_load_index (i_load_index),
        .i_load_value (i_load_value),
        .i_freq       (i_freq),
        .i_trig       (i_trig),
        .i_gate       (i_gate),
        .i_amp        (i_amp),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_sample_out (o_sample_out),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // oscillator state as the testbench sees it
    logic [15:0]         smem [0:65535];
    bit                  smem_written [0:65535];
    logic [PHASE_W-1:0]  ph_pos = '0;
    logic [ADV_W-1:0]    ph_adv = '0;
    logic                prev_trig = 1'b0;
    logic [15:0]         last_out = '0;
    logic [FREQ_W-1:0]   reg_orig = '0;
    logic [RATE_W-1:0]   reg_rate = RATE_W'(44100);
    logic [LEN_W-1:0]    reg_len = '0;

    logic [15:0] want_samples [$];
    t_row        dir_rows [$];
    int          err_cnt = 0;
    int          idle_cyc = 0;
    logic [15:0] want_now;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic flag_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
        $display("mismatch at %0t: %s got %0d want %0d", $realtime, what,
                 $signed(got), $signed(want));
        err_cnt++;
    endtask

    function automatic logic [LEN_W-1:0] eff_length();
        return (reg_len > 17'd65536) ? 17'd65536 : reg_len;
    endfunction

    function automatic logic [15:0] scale_sample(input logic [AMP_W-1:0] amp,
                                                 input logic [15:0] w);
        logic signed [35:0] prod;
        logic signed [35:0] q;
        prod = $signed({19'd0, amp}) * $signed({{20{w[15]}}, w});
        q = prod >>> FRAC_W;
        if (q > 36'sd32767)
            return 16'h7FFF;
        if (q < -36'sd32768)
            return 16'h8000;
        return q[15:0];
    endfunction

    // sample index a gate-high tick would read now, -1 when nothing is read
    function automatic int tick_index();
        logic [PHASE_W-1:0] span;
        logic [PHASE_W-1:0] p;
        if (eff_length() == 0)
            return -1;
        span = {3'b0, eff_length(), 16'b0};
        p = (ph_pos >= span) ? ph_pos % span : ph_pos;
        return int'(p[31:16]);
    endfunction

    task automatic step_oscillator(input t_req r, output logic has_res,
                                   output logic [15:0] res);
        logic [47:0]        num;
        logic [47:0]        den;
        logic [PHASE_W-1:0] span;
        has_res = 1'b0;
        res = '0;
        case (r.action)
            ACT_LOAD: begin
                smem[r.index] = r.value;
                smem_written[r.index] = 1'b1;
            end
            ACT_CTRL: begin
                if (r.trig && !prev_trig)
                    ph_pos = '0;
                prev_trig = r.trig;
                num = 48'({r.freq, 16'b0}) * 48'(reg_orig);
                den = 48'(44000) * 48'(reg_rate);
                ph_adv = (den == 0) ? '0 : ADV_W'(num / den);
            end
            ACT_TICK: begin
                if (r.gate) begin
                    if (eff_length() == 0) begin
                        last_out = '0;
                    end else begin
                        span = {3'b0, eff_length(), 16'b0};
                        if (ph_pos >= span)
                            ph_pos = ph_pos % span;
                        last_out = scale_sample(r.amp, smem[ph_pos[31:16]]);
                        ph_pos = ph_pos + PHASE_W'(ph_adv);
                        if (ph_pos >= span)
                            ph_pos = ph_pos % span;
                    end
                end
                res = last_out;
                has_res = 1'b1;
            end
            default: ;
        endcase
    endtask

    function automatic t_req rand_junk();
        t_req r;
        r.action = ACT_W'($urandom);
        r.index = 16'($urandom);
        r.value = 16'($urandom);
        r.freq = 16'($urandom);
        r.trig = 1'($urandom);
        r.gate = 1'($urandom);
        r.amp = AMP_W'($urandom);
        return r;
    endfunction

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [AMP_W-1:0] pick_amp();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 17'd65536;
            2: return 17'h1FFFF;
            3: return AMP_W'($urandom);
            default: return AMP_W'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic logic [FREQ_W-1:0] pick_freq();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 16'hFFFF;
            2: return FREQ_W'($urandom_range(0, 15));
            default: return FREQ_W'($urandom);
        endcase
    endfunction

    function automatic t_req gen_item();
        t_req r;
        int   sel;
        int   top;
        r = rand_junk();
        sel = $urandom_range(0, 99);
        top = (eff_length() == 0) ? 63 : int'(eff_length()) - 1;
        if (sel < 50) begin
            r.action = ACT_TICK;
            r.gate = ($urandom_range(0, 4) != 0);
            r.amp = pick_amp();
        end else if (sel < 68) begin
            r.action = ACT_CTRL;
            r.freq = pick_freq();
        end else if (sel < 93) begin
            r.action = ACT_LOAD;
            if ($urandom_range(0, 9) < 7)
                r.index = 16'($urandom_range(0, top));
            r.value = pick_value();
        end else begin
            r.action = ACT_NONE;
        end
        return r;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_req(input t_req r, input logic fixed, input logic [15:0] fixed_val);
        logic        has_res;
        logic [15:0] res;
        i_in_valid <= 1'b1;
        i_action <= r.action;
        i_load_index <= r.index;
        i_load_value <= r.value;
        i_freq <= r.freq;
        i_trig <= r.trig;
        i_gate <= r.gate;
        i_amp <= r.amp;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1)
            @(posedge i_clk);
        step_oscillator(r, has_res, res);
        if (has_res)
            want_samples.push_back(fixed ? fixed_val : res);
        @(negedge i_clk);
    endtask

    // a tick must never read an unwritten word, so load it first
    task automatic run_item(input t_req r, input logic fixed, input logic [15:0] fixed_val);
        int   idx;
        t_req ld;
        if (r.action == ACT_TICK && r.gate) begin
            idx = tick_index();
            if (idx >= 0 && !smem_written[idx]) begin
                ld = rand_junk();
                ld.action = ACT_LOAD;
                ld.index = 16'(idx);
                ld.value = pick_value();
                send_req(ld, 1'b0, '0);
            end
        end
        send_req(r, fixed, fixed_val);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_ORIG_FREQ:   reg_orig = data[15:0];
            CFG_SAMPLE_RATE: reg_rate = data;
            CFG_SAMPLE_LEN:  reg_len = data[16:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // control requests give no result, so wait out their latency as well
    task automatic drain();
        i_in_valid <= 1'b0;
        while (want_samples.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic add_row(input int ph, input logic [ACT_W-1:0] act, input int idx,
                           input int val, input int freq, input int trig, input int gate,
                           input int amp, input int fixed, input int fixed_val);
        t_row row;
        row.req = rand_junk();
        row.req.action = act;
        if (act == ACT_LOAD) begin
            row.req.index = 16'(idx);
            row.req.value = 16'(val);
        end
        if (act == ACT_CTRL) begin
            row.req.freq = FREQ_W'(freq);
            row.req.trig = 1'(trig);
        end
        if (act == ACT_TICK) begin
            row.req.gate = 1'(gate);
            row.req.amp = AMP_W'(amp);
        end
        row.fixed = 1'(fixed);
        row.fixed_val = 16'(fixed_val);
        row.ph = ph;
        dir_rows.push_back(row);
    endtask

    task automatic build_directed();
        // reset settings: zero length, zero reference frequency
        add_row(0, ACT_TICK, 0, 0, 0, 0, 0, 17'd65536, 1, 16'h0000);
        add_row(0, ACT_TICK, 0, 0, 0, 0, 1, 17'd65536, 1, 16'h0000);
        add_row(0, ACT_NONE, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(0, ACT_CTRL, 0, 0, 16'hFFFF, 1, 0, 0, 0, 0);
        add_row(0, ACT_LOAD, 16'd0, 16'h7FFF, 0, 0, 0, 0, 0, 0);
        add_row(0, ACT_LOAD, 16'd1, 16'h8000, 0, 0, 0, 0, 0, 0);
        add_row(0, ACT_LOAD, 16'd2, 16'h1234, 0, 0, 0, 0, 0, 0);
        add_row(0, ACT_LOAD, 16'd3, 16'hFFFF, 0, 0, 0, 0, 0, 0);
        add_row(0, ACT_LOAD, 16'hFFFF, 16'h8001, 0, 0, 0, 0, 0, 0);
        // one sample per tick, loop of eight
        add_row(1, ACT_CTRL, 0, 0, 16'd1, 0, 0, 0, 0, 0);
        add_row(1, ACT_CTRL, 0, 0, 16'd1, 1, 0, 0, 0, 0);
        add_row(1, ACT_TICK, 0, 0, 0, 0, 1, 17'd65536, 1, 16'h7FFF);
        add_row(1, ACT_TICK, 0, 0, 0, 0, 1, 17'd65536, 1, 16'h8000);
        add_row(1, ACT_TICK, 0, 0, 0, 0, 1, 17'd0, 1, 16'h0000);
        add_row(1, ACT_TICK, 0, 0, 0, 0, 0, 17'd65536, 1, 16'h0000);
        // floor shift of a tiny negative product
        add_row(1, ACT_TICK, 0, 0, 0, 0, 1, 17'd1, 1, 16'hFFFF);
        add_row(1, ACT_CTRL, 0, 0, 16'd1, 0, 0, 0, 0, 0);
        add_row(1, ACT_CTRL, 0, 0, 16'd1, 1, 0, 0, 0, 0);
        // saturation both ways
        add_row(1, ACT_TICK, 0, 0, 0, 0, 1, 17'h1FFFF, 1, 16'h7FFF);
        add_row(1, ACT_TICK, 0, 0, 0, 0, 1, 17'h1FFFF, 1, 16'h8000);
        add_row(1, ACT_TICK, 0, 0, 0, 0, 1, 17'd65535, 0, 0);
        add_row(1, ACT_CTRL, 0, 0, 16'd3, 1, 0, 0, 0, 0);
        add_row(1, ACT_TICK, 0, 0, 0, 0, 1, 17'd40000, 0, 0);
        add_row(1, ACT_TICK, 0, 0, 0, 0, 1, 17'd65536, 0, 0);
        add_row(1, ACT_TICK, 0, 0, 0, 0, 1, 17'd65536, 0, 0);
    endtask

    task automatic random_phase(input int p);
        logic [FREQ_W-1:0] orig;
        logic [RATE_W-1:0] rate;
        logic [LEN_W-1:0]  len;
        int                left;
        int                burst;
        int                gap;
        bit                no_gaps;
        t_req              r;
        case (p)
            0: begin orig = 16'hFFFF; rate = 18'd1; len = 17'd4; end
            1: begin orig = 16'($urandom); rate = 18'd192000; len = 17'd65536; end
            2: begin orig = 16'hFFFF; rate = 18'd0; len = 17'h1FFFF; end
            3: begin orig = 16'hFFFF; rate = 18'h3FFFF; len = 17'd1; end
            4: begin orig = 16'd0; rate = 18'd44100; len = 17'd0; end
            5: begin orig = 16'($urandom); rate = RATE_W'($urandom_range(1, 50)); len = 17'd2; end
            6: begin orig = 16'hFFFF; rate = 18'd1; len = 17'd65536; end
            default: begin
                orig = 16'($urandom);
                rate = RATE_W'($urandom_range(8000, 192000));
                len = LEN_W'($urandom_range(3, 64));
            end
        endcase
        drain();
        // spare upper data bits beyond each register are noise
        cfg_write(CFG_ORIG_FREQ, {2'($urandom), orig});
        cfg_write(CFG_SAMPLE_RATE, rate);
        cfg_write(CFG_SAMPLE_LEN, {1'($urandom), len});
        cfg_write(CFG_NONE, CFG_W'($urandom));
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        no_gaps = (p % 3 == 2);
        left = ITEMS_PER_PHASE;
        while (left > 0) begin
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst && left > 0; k++) begin
                r = gen_item();
                run_item(r, 1'b0, '0);
                left--;
            end
            gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 24) : 0;
            if (left > 0 && !no_gaps && gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    // receiver: long stretches of a repeating stall pattern, random stalls or none
    int          rx_left = 0;
    int          rx_mode = 0;
    logic [15:0] rx_pat = 16'h0001;

    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_left = $urandom_range(50, 400);
            rx_mode = $urandom_range(0, 2);
            rx_pat = 16'($urandom) | 16'h0001;
        end
        rx_left--;
        case (rx_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= rx_pat[0];
            default: i_out_ready <= ($urandom_range(0, 3) == 0);
        endcase
        rx_pat = {rx_pat[0], rx_pat[15:1]};
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (want_samples.size() == 0) begin
                flag_mismatch("sample_out with no tick pending", o_sample_out, 'x);
            end else begin
                want_now = want_samples.pop_front();
                if (o_sample_out !== want_now)
                    flag_mismatch("sample_out", o_sample_out, want_now);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready === 1'b1) || (o_out_valid === 1'b1 && i_out_ready))
            idle_cyc <= 0;
        else
            idle_cyc <= idle_cyc + 1;
        if (idle_cyc >= WATCHDOG_LIMIT) begin
            $display("watchdog: no request or result moved for %0d cycles", idle_cyc);
            $display("** sample_playback_oscillator_unit: FAILED **");
            $finish;
        end
    end

    initial begin
        int cur_ph;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_action = ACT_LOAD;
        i_load_index = '0;
        i_load_value = '0;
        i_freq = '0;
        i_trig = 1'b0;
        i_gate = 1'b0;
        i_amp = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_ORIG_FREQ;
        i_cfg_data = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        build_directed();
        cur_ph = 0;
        foreach (dir_rows[n]) begin
            if (dir_rows[n].ph != cur_ph) begin
                drain();
                cfg_write(CFG_ORIG_FREQ, 18'd44000);
                cfg_write(CFG_SAMPLE_RATE, 18'd1);
                cfg_write(CFG_SAMPLE_LEN, 18'd8);
                i_cfg_we <= 1'b0;
                @(negedge i_clk);
                cur_ph = dir_rows[n].ph;
            end
            run_item(dir_rows[n].req, dir_rows[n].fixed, dir_rows[n].fixed_val);
        end

        for (int p = 0; p < RAND_PHASES; p++)
            random_phase(p);

        drain();
        if (err_cnt == 0)
            $display("** sample_playback_oscillator_unit: PASSED **");
        else
            $display("** sample_playback_oscillator_unit: FAILED **");
        $finish;
    end

endmodule

>>> filelist.f
rtl/spo_pkg.sv
rtl/spo_ram.sv
rtl/spo_div.sv
rtl/sample_playback_oscillator_unit.sv
dv/sample_playback_oscillator_unit_tb.sv
